@@ rtl/pce_pkg.sv @@
// Package with the shared types and constants of the piecewise curve evaluator.
`default_nettype none
package pce_pkg;

	localparam int PCE_MAX_POINTS = 16;
	localparam int PCE_DIV_W = 64;
	localparam logic [63:0] PCE_DELTA_LIMIT = 64'h0000_0100_0000_0000;
	localparam logic [63:0] PCE_SLOPE_POS_LIM = 64'h0000_7FFF_FFFF_FFFF;
	localparam logic [63:0] PCE_SLOPE_NEG_LIM = 64'h0000_8000_0000_0000;
	localparam logic [31:0] PCE_STRAIN_ONE = 32'h0100_0000;
	localparam logic [31:0] PCE_DAMAGE_ONE = 32'h0001_0000;

	typedef enum logic [1:0] {
		REG_POINT_COUNT      = 2'd0,
		REG_STRAIN_TOLERANCE = 2'd1,
		REG_STRESS_TOLERANCE = 2'd2,
		REG_LAW_VALID        = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		OP_Y = 2'd0,
		OP_Q = 2'd1,
		OP_S = 2'd2,
		OP_D = 2'd3
	} op_t;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_EVAL  = 1'b1;

	typedef struct packed {
		logic               action;
		logic [3:0]         point_index;
		logic [30:0]        point_strain;
		logic [31:0]        point_stress;
		logic [31:0]        point_undamaged;
		logic signed [31:0] query_strain;
	} in_item_t;

	typedef struct packed {
		logic [31:0]        stress;
		logic [31:0]        undamaged_stress;
		logic [15:0]        damage;
		logic signed [47:0] slope;
		logic               beyond_last;
	} result_t;

	typedef struct packed {
		logic [30:0] strain;
		logic [31:0] stress;
		logic [31:0] undamaged;
	} entry_t;

	typedef struct packed {
		logic accept_write;
		logic accept_eval;
		logic clear_res;
		logic srch_cmp;
		logic cap_a;
		logic cap_b;
		logic prep;
		logic mul;
		logic div_go;
		logic store;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic law_valid;
		logic hit;
		logic en;
		logic div_done;
	} status_t;

endpackage
`default_nettype wire

@@ rtl/pce_divider.sv @@
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module pce_divider
	import pce_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 go,
	input  wire logic [PCE_DIV_W-1:0] dividend,
	input  wire logic [31:0]          divisor,
	output logic                      done,
	output logic [PCE_DIV_W-1:0]      quotient
);
	localparam int CNT_W = $clog2(PCE_DIV_W + 1);

	logic [PCE_DIV_W-1:0] dvd_q;
	logic [31:0]          rem_q;
	logic [31:0]          dvs_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 done_q;
	logic [32:0]          rem_sh;
	logic [32:0]          rem_sub;
	logic                 ge;

	assign rem_sh  = {rem_q, dvd_q[PCE_DIV_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign ge      = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				cnt_q <= CNT_W'(PCE_DIV_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (cnt_q != '0) begin
			dvd_q <= {dvd_q[PCE_DIV_W-2:0], ge};
			rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule
`default_nettype wire

@@ rtl/pce_datapath.sv @@
// Datapath: registers, point table, multiplier, shared divider and result logic.
`default_nettype none
module pce_datapath
	import pce_pkg::*;
#(
	parameter int MAX_POINTS = PCE_MAX_POINTS,
	parameter int AW = $clog2(MAX_POINTS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_we,
	input  wire logic [1:0]    cfg_index,
	input  wire logic [19:0]   cfg_data,
	input  wire in_item_t      item,
	input  wire cmd_t          cmd,
	input  wire logic [AW-1:0] rd_addr,
	output status_t            st,
	output logic [AW-1:0]      nlast,
	output result_t            result
);
	localparam int CW = (AW + 1 > 5) ? AW + 1 : 5;

	logic [4:0]  point_count_q;
	logic [19:0] strain_tol_q;
	logic [19:0] stress_tol_q;
	logic        law_valid_q;

	entry_t mem [MAX_POINTS];
	entry_t rd_q;
	entry_t a_q, b_q;

	logic signed [31:0] x_q;
	logic               beyond_q;
	logic [31:0]        y_res_q, q_res_q;
	logic [47:0]        slope_res_q;
	logic [15:0]        dmg_res_q;

	logic [31:0] opa_q, opb_q, dvs_q;
	logic        neg_q, en_q;
	logic [63:0] prod_q;

	logic        div_done;
	logic [63:0] qt;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= 5'd2;
			strain_tol_q  <= '0;
			stress_tol_q  <= '0;
			law_valid_q   <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_POINT_COUNT:      point_count_q <= cfg_data[4:0];
				REG_STRAIN_TOLERANCE: strain_tol_q  <= cfg_data;
				REG_STRESS_TOLERANCE: stress_tol_q  <= cfg_data;
				REG_LAW_VALID:        law_valid_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// point count clamped to 2..MAX_POINTS, given as the index of the last point
	logic [CW-1:0] pc_w;
	logic [CW-1:0] nlast_w;
	always_comb begin
		pc_w = CW'(point_count_q);
		if (pc_w < CW'(2)) begin
			nlast_w = CW'(1);
		end else if (pc_w > CW'(MAX_POINTS)) begin
			nlast_w = CW'(MAX_POINTS - 1);
		end else begin
			nlast_w = pc_w - CW'(1);
		end
	end
	assign nlast = nlast_w[AW-1:0];

	// point table
	always_ff @(posedge clk) begin
		if (cmd.accept_write && (int'(item.point_index) < MAX_POINTS)) begin
			mem[AW'(item.point_index)] <= '{strain: item.point_strain,
				stress: item.point_stress, undamaged: item.point_undamaged};
		end
		rd_q <= mem[rd_addr];
	end

	// segment search compare
	logic signed [33:0] x_ext;
	logic signed [33:0] end_ext;
	assign x_ext   = {{2{x_q[31]}}, x_q};
	assign end_ext = $signed({3'b0, rd_q.strain}) + $signed({14'b0, strain_tol_q});

	// segment quantities
	logic signed [32:0] span_c, dy, dq, dxq;
	logic [30:0]        xbase;
	logic               span_pos, dy_pos, dq_pos;
	assign span_c   = $signed({2'b0, b_q.strain}) - $signed({2'b0, a_q.strain});
	assign dy       = $signed({1'b0, b_q.stress}) - $signed({1'b0, a_q.stress});
	assign dq       = $signed({1'b0, b_q.undamaged}) - $signed({1'b0, a_q.undamaged});
	assign xbase    = beyond_q ? b_q.strain : a_q.strain;
	assign dxq      = {x_q[31], x_q} - $signed({2'b0, xbase});
	assign span_pos = !span_c[32] && (span_c != '0);
	assign dy_pos   = !dy[32] && (dy != '0);
	assign dq_pos   = !dq[32] && (dq != '0);

	function automatic logic [31:0] mag33(input logic signed [32:0] v);
		logic [32:0] n;
		n = -v;
		return v[32] ? n[31:0] : v[31:0];
	endfunction

	// operand preparation
	logic [31:0] pa, pb, pd;
	logic        pn, pe;
	always_comb begin
		pa = mag33(dy);
		pb = mag33(dxq);
		pd = span_c[31:0];
		pn = dy[32] ^ dxq[32];
		pe = span_pos && (!beyond_q || dy_pos);
		case (cmd.op)
			OP_Y: ;
			OP_Q: begin
				pa = mag33(dq);
				pn = dq[32] ^ dxq[32];
				pe = span_pos && (!beyond_q || dq_pos);
			end
			OP_S: begin
				pb = PCE_STRAIN_ONE;
				pn = dy[32];
			end
			OP_D: begin
				pa = q_res_q - y_res_q;
				pb = PCE_DAMAGE_ONE;
				pd = q_res_q;
				pn = 1'b0;
				pe = (q_res_q != '0) && (y_res_q < q_res_q);
			end
			default: ;
		endcase
	end

	pce_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (cmd.div_go),
		.dividend (prod_q),
		.divisor  (dvs_q),
		.done     (div_done),
		.quotient (qt)
	);

	// interpolation result: clamp offset, add to base, floor and saturate; slope: clamp and sign
	logic [40:0]        mag41;
	logic signed [41:0] delta;
	logic [31:0]        base;
	logic signed [42:0] sum;
	logic [31:0]        floored;
	logic [63:0]        lim;
	logic [47:0]        smag;
	logic [47:0]        slope_v;
	always_comb begin
		mag41 = (qt > PCE_DELTA_LIMIT) ? PCE_DELTA_LIMIT[40:0] : qt[40:0];
		if (!en_q) begin
			delta = '0;
		end else if (neg_q) begin
			delta = -$signed({1'b0, mag41});
		end else begin
			delta = $signed({1'b0, mag41});
		end
		if (cmd.op == OP_Q) begin
			base = beyond_q ? b_q.undamaged : a_q.undamaged;
		end else begin
			base = beyond_q ? b_q.stress : a_q.stress;
		end
		sum = $signed({11'b0, base}) + {delta[41], delta};
		if (sum < $signed({23'b0, stress_tol_q})) begin
			floored = {12'b0, stress_tol_q};
		end else if (sum > $signed(43'h0_FFFF_FFFF)) begin
			floored = 32'hFFFF_FFFF;
		end else begin
			floored = sum[31:0];
		end
		lim  = neg_q ? PCE_SLOPE_NEG_LIM : PCE_SLOPE_POS_LIM;
		smag = (qt > lim) ? lim[47:0] : qt[47:0];
		if (!en_q) begin
			slope_v = '0;
		end else if (neg_q) begin
			slope_v = -smag;
		end else begin
			slope_v = smag;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_eval) begin
			x_q <= item.query_strain;
		end
		if (cmd.cap_a) begin
			a_q <= rd_q;
		end
		if (cmd.cap_b) begin
			b_q <= rd_q;
		end
		if (cmd.prep) begin
			opa_q <= pa;
			opb_q <= pb;
			dvs_q <= pd;
			neg_q <= pn;
			en_q  <= pe;
		end
		if (cmd.mul) begin
			prod_q <= opa_q * opb_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beyond_q    <= 1'b0;
			y_res_q     <= '0;
			q_res_q     <= '0;
			slope_res_q <= '0;
			dmg_res_q   <= '0;
		end else if (cmd.clear_res) begin
			beyond_q    <= 1'b0;
			y_res_q     <= '0;
			q_res_q     <= '0;
			slope_res_q <= '0;
			dmg_res_q   <= '0;
		end else begin
			if (cmd.srch_cmp) begin
				beyond_q <= !(x_ext <= end_ext);
			end
			if (cmd.store) begin
				case (cmd.op)
					OP_Y:    y_res_q     <= floored;
					OP_Q:    q_res_q     <= floored;
					OP_S:    slope_res_q <= slope_v;
					// A zero stress gives a full unit of damage, held at the top code.
					OP_D:    dmg_res_q   <= !en_q ? 16'd0 :
						(qt > 64'd65535) ? 16'hFFFF : qt[15:0];
					default: ;
				endcase
			end
		end
	end

	assign st.law_valid = law_valid_q;
	assign st.hit       = x_ext <= end_ext;
	assign st.en        = en_q;
	assign st.div_done  = div_done;

	assign result.stress           = y_res_q;
	assign result.undamaged_stress = q_res_q;
	assign result.damage           = dmg_res_q;
	assign result.slope            = $signed(slope_res_q);
	assign result.beyond_last      = beyond_q;
endmodule
`default_nettype wire

@@ rtl/pce_ctrl.sv @@
// Controller state machine: segment search, table reads and arithmetic sequencing.
`default_nettype none
module pce_ctrl
	import pce_pkg::*;
#(
	parameter int MAX_POINTS = PCE_MAX_POINTS,
	parameter int AW = $clog2(MAX_POINTS)
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic          action,
	input  wire status_t       st,
	input  wire logic [AW-1:0] nlast,
	output cmd_t               cmd,
	output logic [AW-1:0]      rd_addr,
	output logic               busy,
	output logic               done
);
	typedef enum logic [11:0] {
		S_IDLE     = 12'b0000_0000_0001,
		S_SRCH_RD  = 12'b0000_0000_0010,
		S_SRCH_CMP = 12'b0000_0000_0100,
		S_RD_A     = 12'b0000_0000_1000,
		S_RD_B     = 12'b0000_0001_0000,
		S_CAP_B    = 12'b0000_0010_0000,
		S_PREP     = 12'b0000_0100_0000,
		S_MUL      = 12'b0000_1000_0000,
		S_DIV_GO   = 12'b0001_0000_0000,
		S_DIV_WAIT = 12'b0010_0000_0000,
		S_STORE    = 12'b0100_0000_0000,
		S_DONE     = 12'b1000_0000_0000
	} state_t;

	state_t        state_q, state_d;
	logic [AW-1:0] idx_q;
	op_t           op_q;
	logic          accept;

	assign accept = start && (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (action == ACT_EVAL)) begin
					state_d = st.law_valid ? S_SRCH_RD : S_DONE;
				end
			end
			S_SRCH_RD:  state_d = S_SRCH_CMP;
			S_SRCH_CMP: begin
				if (st.hit || (idx_q == nlast)) begin
					state_d = S_RD_A;
				end else begin
					state_d = S_SRCH_RD;
				end
			end
			S_RD_A:     state_d = S_RD_B;
			S_RD_B:     state_d = S_CAP_B;
			S_CAP_B:    state_d = S_PREP;
			S_PREP:     state_d = S_MUL;
			S_MUL:      state_d = st.en ? S_DIV_GO : S_STORE;
			S_DIV_GO:   state_d = S_DIV_WAIT;
			S_DIV_WAIT: state_d = st.div_done ? S_STORE : S_DIV_WAIT;
			S_STORE:    state_d = (op_q == OP_D) ? S_DONE : S_PREP;
			S_DONE:     state_d = S_IDLE;
			default:    state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			op_q    <= OP_Y;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE) begin
				idx_q <= AW'(1);
				op_q  <= OP_Y;
			end else if ((state_q == S_SRCH_CMP) && (state_d == S_SRCH_RD)) begin
				idx_q <= idx_q + AW'(1);
			end
			if (state_q == S_STORE) begin
				unique case (op_q)
					OP_Y:    op_q <= OP_Q;
					OP_Q:    op_q <= OP_S;
					OP_S:    op_q <= OP_D;
					OP_D:    op_q <= OP_D;
					default: op_q <= OP_Y;
				endcase
			end
		end
	end

	always_comb begin
		rd_addr = idx_q;
		if (state_q == S_RD_A) begin
			rd_addr = idx_q - AW'(1);
		end
	end

	assign cmd.accept_write = accept && (action == ACT_WRITE);
	assign cmd.accept_eval  = accept && (action == ACT_EVAL);
	assign cmd.clear_res    = accept && (action == ACT_EVAL) && !st.law_valid;
	assign cmd.srch_cmp     = state_q == S_SRCH_CMP;
	assign cmd.cap_a        = state_q == S_RD_B;
	assign cmd.cap_b        = state_q == S_CAP_B;
	assign cmd.prep         = state_q == S_PREP;
	assign cmd.mul          = state_q == S_MUL;
	assign cmd.div_go       = state_q == S_DIV_GO;
	assign cmd.store        = state_q == S_STORE;
	assign cmd.op           = op_q;

	assign busy = state_q != S_IDLE;
	assign done = state_q == S_DONE;
endmodule
`default_nettype wire

@@ rtl/piecewise_curve_evaluator.sv @@
// Top level of the piecewise linear curve evaluator.
//
// An item is taken at a rising edge where start is high and busy is low.
// A write item (action 0) stores one table point in that same cycle and
// leaves busy low, so another item may follow at once. An evaluate item
// (action 1) raises busy and, when it finishes, puts one result on the
// result port, marked by done for exactly one cycle; the receiver cannot
// stall it and must take it in that cycle.
// An evaluate item searches the segments one table read at a time, with
// a read state and a compare state per point visited, then runs four
// multiply and divide passes on one shared radix-2 divider: stress,
// undamaged stress, slope and damage; a pass whose result is fixed skips
// its division. With the law marked invalid the all-zero result comes in
// the next cycle.
// Configuration writes take effect at the edge where cfg_we is high.
// Reset clears the registers to their defaults and returns the controller
// to idle; the point table holds no defined contents until written.
`default_nettype none
module piecewise_curve_evaluator
	import pce_pkg::*;
#(
	parameter int MAX_POINTS = PCE_MAX_POINTS
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [19:0] cfg_data,
	input  wire logic        start,
	output logic             busy,
	input  wire in_item_t    item,
	output logic             done,
	output result_t          result
);
	localparam int AW = $clog2(MAX_POINTS);

	cmd_t          cmd;
	status_t       st;
	logic [AW-1:0] rd_addr;
	logic [AW-1:0] nlast;

	// The controller sequences the search and the arithmetic passes.
	pce_ctrl #(
		.MAX_POINTS (MAX_POINTS),
		.AW         (AW)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.action  (item.action),
		.st      (st),
		.nlast   (nlast),
		.cmd     (cmd),
		.rd_addr (rd_addr),
		.busy    (busy),
		.done    (done)
	);

	// The datapath holds the table, the registers and the arithmetic.
	pce_datapath #(
		.MAX_POINTS (MAX_POINTS),
		.AW         (AW)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.st        (st),
		.nlast     (nlast),
		.result    (result)
	);
endmodule
`default_nettype wire
